FILE: rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst_n, a, c)
`define CHK_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: rtl/pll_pkg.sv
package pll_pkg;
	localparam int KEY_W = 64;
	localparam int EB_W  = 11;
	localparam int ST_W  = 17;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_LOAD   = 2'd1,
		OP_BUILD  = 2'd2,
		OP_LOOKUP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_ORDER   = 2'd2,
		ST_NOTBUILT = 2'd3
	} status_t;

	localparam logic CFG_ERROR_BOUND = 1'b0;
	localparam logic CFG_SEG_TARGET  = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE,
		S_LOAD_RD,
		S_LOAD_CHK,
		S_BLD_DIV,
		S_BLD_SIZE,
		S_BLD_SEG,
		S_BLD_RD,
		S_BLD_WAIT,
		S_BLD_WR,
		S_LK_SEG,
		S_LK_PRE,
		S_LK_DIV,
		S_LK_WIN,
		S_LK_RD,
		S_LK_WAIT,
		S_LK_STEP,
		S_LK_FIN_RD,
		S_LK_FIN_WAIT,
		S_LK_FIN,
		S_OUT
	} state_t;
endpackage

FILE: rtl/pll_ram.sv
module pll_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/pll_div.sv
// restoring divider, one quotient bit per cycle: q = floor(num / den), num < 2^NW
module pll_div
	import pll_pkg::*;
#(
	parameter int NW = 128,
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);
	localparam int CW = $clog2(NW + 1);
	logic [DW:0]   rem_q;
	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   shifted;
	logic [DW:0]   diff;

	assign shifted = {rem_q[DW-1:0], num_q[NW-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
			quot  <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			if (!diff[DW]) begin
				rem_q <= diff;
				quot  <= {quot[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quot  <= {quot[NW-2:0], 1'b0};
			end
		end
	end
endmodule

FILE: rtl/piecewise_linear_learned_lookup_unit.sv
// Lookup: segment scan (one segment a cycle), the shared divider when the key
//   falls strictly inside a segment, then a binary search over the window,
//   each step reading the key memory and then narrowing the bounds.
// Load checks order against the last key; build runs two divides, then each segment.
// One item at a time; the result register frees the input side once taken.
// arst_n clears count, segment count, built flag and config to 64 / 10000.
`include "assert_macros.svh"
module piecewise_linear_learned_lookup_unit
	import pll_pkg::*;
#(
	parameter int KEY_DEPTH    = 65536,
	parameter int MAX_SEGMENTS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,  // operation[1:0], key[65:2], value[129:66]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [87:0]  m_tdata,  // found[0], result_value[64:1], position[80:65], status[82:81]
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [16:0]  cfg_data
);
	localparam int AW = $clog2(KEY_DEPTH);
	localparam int CW = AW + 1;
	localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int SCW = $clog2(MAX_SEGMENTS + 1);

	state_t state_q, state_d;

	logic [EB_W-1:0] eb_q;
	logic [ST_W-1:0] tgt_q;
	logic [CW-1:0]   count_q;
	logic [SCW-1:0]  nseg_q;
	logic            built_q;

	logic [KEY_W-1:0] key_q, val_q;

	logic [KEY_W-1:0] seg_min_q [MAX_SEGMENTS];
	logic [KEY_W-1:0] seg_max_q [MAX_SEGMENTS];
	logic [CW-1:0]    seg_st_q  [MAX_SEGMENTS];
	logic [CW-1:0]    seg_en_q  [MAX_SEGMENTS];

	logic [SCW-1:0]   si_q;
	logic [CW-1:0]    size_q, a_q, b_q, hi_q, pred_q;
	logic [KEY_W-1:0] rd_min_q;

	logic             found_q;
	logic [KEY_W-1:0] rv_q;
	logic [15:0]      pos_q;
	status_t          stat_q;

	// memories
	logic             mem_we;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	logic [KEY_W-1:0] key_rd, val_rd;

	pll_ram #(.WIDTH(KEY_W), .DEPTH(KEY_DEPTH)) u_keys (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(key_q),
		.raddr(mem_raddr), .rdata(key_rd));
	pll_ram #(.WIDTH(KEY_W), .DEPTH(KEY_DEPTH)) u_vals (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(val_q),
		.raddr(mem_raddr), .rdata(val_rd));

	// shared divider
	logic         div_start, div_done;
	logic [127:0] div_num, div_quot;
	logic [63:0]  div_den;
	pll_div #(.NW(128), .DW(64)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quot(div_quot));

	logic [SW-1:0] si;
	assign si = si_q[SW-1:0];

	logic [CW-1:0] mid;
	assign mid = a_q + ((b_q - a_q) >> 1);

	// lookup prep products registered in S_LK_SEG
	logic [CW-1:0] seg_n;
	assign seg_n = seg_en_q[si] - seg_st_q[si];

	logic [CW-1:0] num_clamp;
	always_comb begin
		num_clamp = div_quot[CW-1:0];
		if (div_quot[127:CW] != '0) begin
			num_clamp = CW'(MAX_SEGMENTS);
		end
		if (tgt_q == '0) begin
			num_clamp = CW'(MAX_SEGMENTS);
		end
		if (num_clamp > CW'(MAX_SEGMENTS)) begin
			num_clamp = CW'(MAX_SEGMENTS);
		end
		if (num_clamp > count_q) begin
			num_clamp = count_q;
		end
		if (num_clamp == '0) begin
			num_clamp = CW'(1);
		end
	end

	// mul for window prediction: d * (n-1), d up to 64 bits, computed as 64x17 in S_LK_SEG
	logic [127:0] prod_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid && s_tready) begin
					unique case (op_t'(s_tdata[1:0]))
						OP_CLEAR:  state_d = S_OUT;
						OP_LOAD:   state_d = S_LOAD_RD;
						OP_BUILD:  state_d = S_BLD_DIV;
						OP_LOOKUP: state_d = S_LK_SEG;
						default:   state_d = S_OUT;
					endcase
				end
			end
			S_LOAD_RD:  state_d = S_LOAD_CHK;
			S_LOAD_CHK: state_d = S_OUT;
			S_BLD_DIV: state_d = (count_q == '0) ? S_OUT : S_BLD_SIZE;
			S_BLD_SIZE: if (div_done) state_d = S_BLD_SEG;
			S_BLD_SEG: if (div_done) state_d = S_BLD_RD;
			S_BLD_RD: state_d = S_BLD_WAIT;
			S_BLD_WAIT: state_d = S_BLD_WR;
			S_BLD_WR: state_d = (si_q + 1'b1 == nseg_q) ? S_OUT : S_BLD_RD;
			S_LK_SEG: begin
				if (!built_q || count_q == '0 || si_q == nseg_q) begin
					state_d = S_OUT;
				end else if (seg_max_q[si] >= key_q) begin
					state_d = S_LK_PRE;
				end
			end
			S_LK_PRE: state_d = S_LK_DIV;
			S_LK_DIV: if (div_done || pred_q != '1) state_d = S_LK_WIN;
			S_LK_WIN: state_d = S_LK_RD;
			S_LK_RD: state_d = (a_q < b_q) ? S_LK_WAIT : S_LK_FIN_RD;
			S_LK_WAIT: state_d = S_LK_STEP;
			S_LK_STEP: state_d = S_LK_RD;
			S_LK_FIN_RD: state_d = S_LK_FIN_WAIT;
			S_LK_FIN_WAIT: state_d = S_LK_FIN;
			S_LK_FIN: state_d = S_OUT;
			S_OUT: if (m_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == S_IDLE);
		m_tvalid  = (state_q == S_OUT);
		m_tdata   = {5'd0, stat_q, pos_q, rv_q, found_q};
		mem_we    = (state_q == S_LOAD_CHK) && stat_q == ST_OK
			&& !(count_q != '0 && key_q < key_rd);
		mem_waddr = count_q[AW-1:0];
		mem_raddr = AW'(count_q - 1'b1);
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (state_q)
			S_BLD_DIV: begin
				div_start = (count_q != '0);
				div_num   = 128'(count_q);
				div_den   = (tgt_q == '0) ? 64'd1 : 64'(tgt_q);
			end
			S_BLD_SIZE: begin
				div_start = div_done;
				div_num   = 128'(count_q);
				div_den   = 64'(num_clamp);
			end
			S_BLD_RD:   mem_raddr = AW'(a_q);
			S_BLD_WAIT: mem_raddr = AW'(b_q - 1'b1);
			S_LK_PRE: begin
				div_start = (pred_q == '1);
				div_num   = prod_q;
				div_den   = seg_max_q[si] - rd_min_q;
			end
			// hold the address so the read data stays valid for the compare
			S_LK_RD, S_LK_WAIT:          mem_raddr = AW'(mid);
			S_LK_FIN_RD, S_LK_FIN_WAIT:  mem_raddr = AW'(a_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			eb_q    <= EB_W'(64);
			tgt_q   <= ST_W'(10000);
			count_q <= '0;
			nseg_q  <= '0;
			built_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == CFG_ERROR_BOUND) eb_q <= cfg_data[EB_W-1:0];
				else tgt_q <= cfg_data[ST_W-1:0];
			end
			if (state_q == S_IDLE && s_tvalid && op_t'(s_tdata[1:0]) == OP_CLEAR) begin
				count_q <= '0;
				nseg_q  <= '0;
				built_q <= 1'b0;
			end
			if (mem_we) begin
				count_q <= count_q + 1'b1;
				built_q <= 1'b0;
			end
			if (state_q == S_BLD_SEG && div_done) begin
				nseg_q <= SCW'(hi_q);
			end
			if (state_q == S_BLD_WR && state_d == S_OUT) begin
				built_q <= 1'b1;
			end
		end
	end

	logic [CW-1:0] eb_ext;
	assign eb_ext = CW'(eb_q);

	// window bounds; the top sum gets one extra bit so it cannot wrap
	logic [CW-1:0] win_act, win_end;
	logic [CW:0]   win_top;
	assign win_act = seg_st_q[si] + pred_q;
	assign win_top = {1'b0, win_act} + {1'b0, eb_ext};
	assign win_end = (win_top > {1'b0, seg_en_q[si]}) ? seg_en_q[si] : win_top[CW-1:0];

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				key_q   <= s_tdata[65:2];
				val_q   <= s_tdata[129:66];
				found_q <= 1'b0;
				rv_q    <= '0;
				pos_q   <= '0;
				stat_q  <= (s_tdata[1:0] == OP_LOAD && count_q == CW'(KEY_DEPTH))
					? ST_FULL : ST_OK;
				si_q    <= '0;
			end
			S_LOAD_CHK: begin
				if (stat_q == ST_OK && count_q != '0 && key_q < key_rd) begin
					stat_q <= ST_ORDER;
				end
			end
			S_BLD_DIV: begin
				if (count_q == '0) stat_q <= ST_NOTBUILT;
			end
			S_BLD_SEG: begin
				if (div_done) begin
					size_q <= div_quot[CW-1:0];
					a_q    <= '0;
					b_q    <= (hi_q == CW'(1)) ? count_q : div_quot[CW-1:0];
				end
			end
			S_BLD_SIZE: begin
				if (div_done) hi_q <= num_clamp;
			end
			S_BLD_WR: begin
				seg_st_q[si]  <= a_q;
				seg_en_q[si]  <= b_q;
				seg_min_q[si] <= rd_min_q;
				seg_max_q[si] <= key_rd;
				si_q <= si_q + 1'b1;
				a_q  <= b_q;
				b_q  <= (CW'(si_q) + CW'(2) == hi_q) ? count_q : b_q + size_q;
			end
			S_BLD_WAIT: rd_min_q <= key_rd;
			S_LK_SEG: begin
				if (!built_q || count_q == '0) begin
					stat_q <= ST_NOTBUILT;
				end else if (si_q != nseg_q && seg_max_q[si] < key_q) begin
					si_q <= si_q + 1'b1;
				end
				rd_min_q <= seg_min_q[si];
				prod_q   <= 128'(key_q - seg_min_q[si]) * 128'(seg_n - 1'b1);
				// pred_q all-ones marks "divide needed"
				if (seg_n <= CW'(1) || key_q <= seg_min_q[si]) pred_q <= '0;
				else if (key_q >= seg_max_q[si]) pred_q <= seg_n - 1'b1;
				else pred_q <= '1;
			end
			S_LK_DIV: begin
				if (div_done) begin
					pred_q <= (div_quot > 128'(seg_n - 1'b1)) ? seg_n - 1'b1
						: div_quot[CW-1:0];
				end
			end
			S_LK_WIN: begin
				a_q  <= (win_act >= eb_ext) ? win_act - eb_ext : seg_st_q[si];
				b_q  <= win_end;
				hi_q <= win_end;
			end
			S_LK_STEP: begin
				if (key_rd < key_q) a_q <= mid + 1'b1;
				else b_q <= mid;
			end
			S_LK_FIN: begin
				if (a_q < hi_q && key_rd == key_q) begin
					found_q <= 1'b1;
					rv_q    <= val_rd;
					pos_q   <= 16'(a_q);
				end
			end
			default: ;
		endcase
	end

	`CHK_IMPL(a_rdy_out, clk, arst_n, m_tvalid, !s_tready)
	`CHK_IMPL(a_cnt_max, clk, arst_n, 1'b1, count_q <= CW'(KEY_DEPTH))
	`CHK_IMPL(a_seg_max, clk, arst_n, 1'b1, nseg_q <= SCW'(MAX_SEGMENTS))
	`CHK_NEXT(a_found_ok, clk, arst_n, m_tvalid && m_tdata[0], m_tdata[82:81] == ST_OK)
endmodule

FILE: tb/pll_lookup_checker.sv
`timescale 1ns / 1ps
module pll_lookup_checker
	import pll_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [135:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [87:0]  m_tdata,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [16:0]  cfg_data,
	output int           pending,
	output int           errors
);
	localparam int KEY_CAP = 65536;
	localparam int SEG_CAP = 8;

	typedef struct packed {
		logic        found;
		logic [63:0] value;
		logic [15:0] position;
		status_t     status;
	} lookup_res_t;

	logic [63:0] key_mem [KEY_CAP];
	logic [63:0] val_mem [KEY_CAP];
	logic [63:0] seg_lo [SEG_CAP];
	logic [63:0] seg_hi [SEG_CAP];
	int unsigned seg_first [SEG_CAP];
	int unsigned seg_last [SEG_CAP];
	int unsigned n_keys, n_segs;
	bit          is_built;
	int unsigned window_half, keys_per_seg;
	lookup_res_t answer_q [$];

	assign pending = answer_q.size();

	function automatic int unsigned local_guess(int unsigned s, logic [63:0] k);
		int unsigned n;
		logic [127:0] q;
		n = seg_last[s] - seg_first[s];
		if (n <= 1 || k <= seg_lo[s])
			return 0;
		if (k >= seg_hi[s])
			return n - 1;
		q = ({64'd0, k - seg_lo[s]} * 128'(n - 1)) / {64'd0, seg_hi[s] - seg_lo[s]};
		if (q > 128'(n - 1))
			return n - 1;
		return int'(q);
	endfunction

	function automatic void cut_segments();
		int unsigned num, size;
		num = (keys_per_seg == 0) ? SEG_CAP : n_keys / keys_per_seg;
		if (num > SEG_CAP)
			num = SEG_CAP;
		if (num > n_keys)
			num = n_keys;
		if (num < 1)
			num = 1;
		size = n_keys / num;
		for (int unsigned i = 0; i < num; i++) begin
			seg_first[i] = i * size;
			seg_last[i] = (i == num - 1) ? n_keys : (i + 1) * size;
			seg_lo[i] = key_mem[seg_first[i]];
			seg_hi[i] = key_mem[seg_last[i] - 1];
		end
		n_segs = num;
		is_built = 1;
	endfunction

	function automatic lookup_res_t search_key(logic [63:0] k);
		lookup_res_t r;
		int unsigned s, guess, lo, hi, a, b, mid;
		r = '{found: 1'b0, value: '0, position: '0, status: ST_OK};
		s = 0;
		while (s < n_segs && seg_hi[s] < k)
			s++;
		if (s < n_segs) begin
			guess = seg_first[s] + local_guess(s, k);
			lo = (guess >= window_half) ? guess - window_half : seg_first[s];
			hi = guess + window_half;
			if (hi > seg_last[s])
				hi = seg_last[s];
			if (lo < hi) begin
				a = lo;
				b = hi;
				while (a < b) begin
					mid = a + (b - a) / 2;
					if (key_mem[mid] < k)
						a = mid + 1;
					else
						b = mid;
				end
				if (a < hi && key_mem[a] == k) begin
					r.found = 1'b1;
					r.value = val_mem[a];
					r.position = a[15:0];
				end
			end
		end
		return r;
	endfunction

	function automatic lookup_res_t apply_beat(op_t op, logic [63:0] k, logic [63:0] v);
		lookup_res_t r;
		r = '{found: 1'b0, value: '0, position: '0, status: ST_OK};
		case (op)
			OP_CLEAR: begin
				n_keys = 0;
				n_segs = 0;
				is_built = 0;
			end
			OP_LOAD: begin
				if (n_keys >= KEY_CAP)
					r.status = ST_FULL;
				else if (n_keys > 0 && k < key_mem[n_keys - 1])
					r.status = ST_ORDER;
				else begin
					key_mem[n_keys] = k;
					val_mem[n_keys] = v;
					n_keys++;
					is_built = 0;
				end
			end
			OP_BUILD: begin
				if (n_keys == 0)
					r.status = ST_NOTBUILT;
				else
					cut_segments();
			end
			default: begin
				if (!is_built || n_keys == 0)
					r.status = ST_NOTBUILT;
				else
					r = search_key(k);
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lookup_res_t got, want;
		if (!arst_n) begin
			n_keys = 0;
			n_segs = 0;
			is_built = 0;
			window_half = 64;
			keys_per_seg = 10000;
			answer_q.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_ERROR_BOUND)
					window_half = cfg_data[10:0];
				else
					keys_per_seg = cfg_data;
			end
			if (m_tvalid && m_tready) begin
				got = '{found: m_tdata[0], value: m_tdata[64:1], position: m_tdata[80:65],
					status: status_t'(m_tdata[82:81])};
				if (answer_q.size() == 0) begin
					$display("%0t: unexpected result beat %h", $time, m_tdata);
					errors++;
				end else begin
					want = answer_q.pop_front();
					if (got.found !== want.found) begin
						$display("%0t: found exp %0d got %0d", $time, want.found, got.found);
						errors++;
					end
					if (got.value !== want.value) begin
						$display("%0t: value exp %h got %h", $time, want.value, got.value);
						errors++;
					end
					if (got.position !== want.position) begin
						$display("%0t: position exp %0d got %0d", $time, want.position,
							got.position);
						errors++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status exp %s got %s", $time, want.status.name(),
							got.status.name());
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				answer_q.insert(answer_q.size(), apply_beat(op_t'(s_tdata[1:0]),
					s_tdata[65:2], s_tdata[129:66]));
		end
	end
endmodule

FILE: tb/tb_piecewise_linear_learned_lookup_unit.sv
`timescale 1ns / 1ps
module tb_piecewise_linear_learned_lookup_unit;
	import pll_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int KEY_CAP = 65536;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [87:0]  m_tdata;
	logic         cfg_we;
	logic         cfg_index;
	logic [16:0]  cfg_data;
	int           pending, errors;
	int           stall_cycles;
	int           phase_items;
	bit           calm;
	logic [63:0]  stored_keys [$];

	piecewise_linear_learned_lookup_unit dut (.*);

	pll_lookup_checker chk (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk)
		m_tready <= calm || ($urandom_range(99) >= 18);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_piecewise_linear_learned_lookup_unit NOT OK");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send(op_t op, logic [63:0] k, logic [63:0] v);
		if (!calm && $urandom_range(99) < 18) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {6'd0, v, k, op};
		do @(posedge clk); while (!s_tready);
		phase_items++;
	endtask

	task automatic load(logic [63:0] k, logic [63:0] v);
		send(OP_LOAD, k, v);
		if (stored_keys.size() < KEY_CAP &&
			(stored_keys.size() == 0 || k >= stored_keys[$]))
			stored_keys.insert(stored_keys.size(), k);
	endtask

	// drain every outstanding result before touching the registers
	task automatic settle();
		s_tvalid <= 0;
		do @(negedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [16:0] d);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic load_run(int n, int shift);
		logic [63:0] k, nk;
		k = rand64() >> $urandom_range(0, 63);
		for (int i = 0; i < n; i++) begin
			if (stored_keys.size() > 0 && stored_keys[$] != 0 && $urandom_range(99) < 5)
				send(OP_LOAD, rand64() % stored_keys[$], rand64());
			load(k, rand64());
			nk = k + ($urandom_range(99) < 10 ? 64'd0 : rand64() >> shift);
			k = (nk < k) ? '1 : nk;
		end
	endtask

	task automatic probe_keys(int n);
		logic [63:0] k;
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (stored_keys.size() == 0 || sel < 20)
				k = rand64();
			else if (sel < 30)
				k = stored_keys[$urandom_range(stored_keys.size() - 1)] +
					($urandom_range(1) ? 64'd1 : -64'd1);
			else if (sel < 36)
				k = $urandom_range(1) ? 64'd0 : '1;
			else
				k = stored_keys[$urandom_range(stored_keys.size() - 1)];
			send(OP_LOOKUP, k, rand64());
		end
	endtask

	initial begin
		logic [16:0] eb, tgt;
		int n;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		m_tready = 0;
		cfg_we = 0;
		cfg_index = CFG_ERROR_BOUND;
		cfg_data = '0;
		stall_cycles = 0;
		phase_items = 0;
		calm = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty store, extremes, order rule, stale segments
		send(OP_LOOKUP, 64'd5, '0);
		send(OP_BUILD, '0, '0);
		load(64'd0, '1);
		load(64'd0, 64'd0);
		load(64'h5555_aaaa_5555_aaaa, 64'haaaa_5555_aaaa_5555);
		load('1, 64'h1234_5678_9abc_def0);
		send(OP_LOAD, 64'd7, '1);
		send(OP_LOOKUP, 64'd0, '0);
		send(OP_BUILD, '0, '0);
		send(OP_LOOKUP, 64'd0, '0);
		send(OP_LOOKUP, '1, '0);
		send(OP_LOOKUP, 64'h5555_aaaa_5555_aaaa, '0);
		send(OP_LOOKUP, 64'd3, '0);
		load('1, 64'd9);
		send(OP_LOOKUP, '1, '0);
		send(OP_BUILD, '0, '0);
		send(OP_LOOKUP, '1, '0);
		send(OP_CLEAR, '0, '0);
		stored_keys.delete();
		send(OP_LOOKUP, 64'd0, '0);
		settle();

		// wide window (error bound 1024), one large segment
		calm = 1;
		write_reg(CFG_ERROR_BOUND, 17'd1024);
		write_reg(CFG_SEG_TARGET, 17'd8192);
		send(OP_CLEAR, '0, '0);
		stored_keys.delete();
		load_run(300, 16);
		send(OP_LOAD, '1, '1);
		send(OP_BUILD, '0, '0);
		calm = 0;
		probe_keys(40);
		settle();
		write_reg(CFG_SEG_TARGET, 17'd65536);
		send(OP_BUILD, '0, '0);
		probe_keys(20);
		settle();

		for (int ph = 0; phase_items < 1600; ph++) begin
			calm = (ph % 6 == 3);
			case ($urandom_range(5))
				0: eb = 17'd0;
				1: eb = 17'd1;
				2: eb = 17'd1024;
				3: eb = 17'd2047;
				default: eb = $urandom_range(1, 16);
			endcase
			case ($urandom_range(5))
				0: tgt = 17'd8192;
				1: tgt = 17'd65536;
				2: tgt = 17'h1ffff;
				default: tgt = 17'd0;
			endcase
			write_reg(CFG_ERROR_BOUND, eb);
			write_reg(CFG_SEG_TARGET, tgt);
			send(OP_CLEAR, '0, '0);
			stored_keys.delete();
			n = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 120);
			load_run(n, $urandom_range(0, 40));
			send(OP_BUILD, '0, '0);
			probe_keys($urandom_range(20, 50));
			if ($urandom_range(3) == 0) begin
				load_run($urandom_range(1, 5), $urandom_range(20, 60));
				probe_keys(3);
				send(OP_BUILD, '0, '0);
				probe_keys(10);
			end
			settle();
		end

		settle();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("tb_piecewise_linear_learned_lookup_unit OK");
		else
			$display("tb_piecewise_linear_learned_lookup_unit NOT OK");
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/pll_pkg.sv
rtl/pll_ram.sv
rtl/pll_div.sv
rtl/piecewise_linear_learned_lookup_unit.sv
tb/pll_lookup_checker.sv
tb/tb_piecewise_linear_learned_lookup_unit.sv
